### sv/sstr_pkg.sv
// sstr_pkg: shared types, constants and command lookup for the spi telemetry responder
// no dependencies; imported by sstr_store and spi_slave_telemetry_responder_unit

package sstr_pkg;

	typedef logic [7:0] byte_t;
	typedef logic [3:0] pkt_id_t;
	typedef logic [3:0] idx_t;

	typedef enum logic [1:0] {
		REQ_SPI = 2'd0,
		REQ_WR  = 2'd1,
		REQ_RD  = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		OUT_ZERO,
		OUT_FF,
		OUT_SPI,
		OUT_READ
	} out_kind_t;

	typedef struct packed {
		logic    hit;
		pkt_id_t id;
	} cmd_hit_t;

	typedef struct packed {
		out_kind_t kind;
		logic      pwm;
		logic      in_pkt;
	} s1_ctrl_t;

	localparam int      PACKET_COUNT = 14;
	localparam pkt_id_t IDLE_CODE    = 4'd15;
	localparam pkt_id_t STATUS_ID    = 4'd7;
	localparam pkt_id_t SERVO_ID     = 4'd8;
	localparam byte_t   NO_DATA      = 8'hFF;

	function automatic cmd_hit_t cmd_lookup(input byte_t b);
		cmd_hit_t r;
		r.hit = 1'b1;
		case (b)
			8'h41: r.id = 4'd0;   // A
			8'h47: r.id = 4'd1;   // G
			8'h43: r.id = 4'd2;   // C
			8'h4F: r.id = 4'd3;   // O
			8'h56: r.id = 4'd4;   // V
			8'h54: r.id = 4'd5;   // T
			8'h52: r.id = 4'd6;   // R
			8'h53: r.id = 4'd7;   // S
			8'h50: r.id = 4'd8;   // P
			8'h4D: r.id = 4'd9;   // M
			8'h4C: r.id = 4'd10;  // L
			8'h44: r.id = 4'd11;  // D
			8'h42: r.id = 4'd12;  // B
			8'h55: r.id = 4'd13;  // U
			default: begin
				r.hit = 1'b0;
				r.id  = IDLE_CODE;
			end
		endcase
		return r;
	endfunction

	function automatic logic [4:0] pkt_len(input pkt_id_t id);
		logic [4:0] l;
		case (id)
			4'd0:    l = 5'd6;
			4'd1:    l = 5'd4;
			4'd2:    l = 5'd2;
			4'd3:    l = 5'd2;
			4'd4:    l = 5'd4;
			4'd5:    l = 5'd2;
			4'd6:    l = 5'd2;
			4'd7:    l = 5'd2;
			4'd8:    l = 5'd4;
			4'd9:    l = 5'd6;
			4'd10:   l = 5'd9;
			4'd11:   l = 5'd10;
			4'd12:   l = 5'd2;
			4'd13:   l = 5'd7;
			default: l = 5'd0;
		endcase
		return l;
	endfunction

endpackage

### sv/sstr_store.sv
// sstr_store: packet byte store, single port, read-before-write, registered read
// per-entry valid bits give the all-zero reset; uses sstr_pkg

module sstr_store
	import sstr_pkg::*;
#(
	parameter int DEPTH = 224,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  byte_t         wdata,
	output byte_t         rdata
);

	byte_t            mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic             vld_s1;
	byte_t            rd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_s1  <= 1'b0;
		end else if (en) begin
			vld_s1 <= valid_q[addr];
			if (we) begin
				valid_q[addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rd_s1 <= mem[addr];
			if (we) begin
				mem[addr] <= wdata;
			end
		end
	end

	assign rdata = vld_s1 ? rd_s1 : '0;

endmodule

### sv/spi_slave_telemetry_responder_unit.sv
// spi_slave_telemetry_responder_unit: spi command responder over a telemetry packet store
// pipeline: result beat is registered first in the store read stage alongside ctrl_s1, then in out_q
// throughput: one beat per cycle sustained while m_tready stays high, set by the single store port
// reset: idle, counter zero, store reads as zero at once through per-entry valid bits
// depends on sstr_pkg and sstr_store

module spi_slave_telemetry_responder_unit
	import sstr_pkg::*;
#(
	parameter int SLOT_BYTES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // spi_in[7:0], packet_id[11:8], byte_index[15:12], write_value[23:16]
	input  logic [1:0]  s_tuser,   // req_type[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // spi_out[7:0], read_value[15:8], pwm_update[16], in_packet[17], zeros
);

	localparam int DEPTH = PACKET_COUNT * SLOT_BYTES;
	localparam int AW    = $clog2(DEPTH);

	byte_t   spi_in;
	pkt_id_t packet_id;
	idx_t    byte_index;
	byte_t   write_value;

	pkt_id_t  active_q;
	idx_t     cnt_q;
	pkt_id_t  act_nx;
	idx_t     cnt_nx;
	cmd_hit_t lk;
	pkt_id_t  p;
	idx_t     idx;
	logic     idle;
	logic     local_ok;

	logic          acc;
	logic          adv;
	logic          mem_en;
	logic          mem_we;
	logic [AW-1:0] mem_addr;
	byte_t         mem_wdata;
	byte_t         rdata;

	s1_ctrl_t ctrl;
	s1_ctrl_t ctrl_s1;
	logic     v_s1;
	logic     out_v_q;
	logic [23:0] out_q;
	byte_t    spi_out;
	byte_t    read_value;

	assign spi_in      = s_tdata[7:0];
	assign packet_id   = s_tdata[11:8];
	assign byte_index  = s_tdata[15:12];
	assign write_value = s_tdata[23:16];

	assign adv      = v_s1 && (!out_v_q || m_tready);
	assign s_tready = !v_s1 || adv;
	assign acc      = s_tvalid && s_tready;

	assign local_ok = (packet_id < 4'(PACKET_COUNT)) && ({1'b0, byte_index} < 5'(SLOT_BYTES));

	always_comb begin
		act_nx      = active_q;
		cnt_nx      = cnt_q;
		mem_en      = 1'b0;
		mem_we      = 1'b0;
		mem_addr    = AW'(packet_id) * AW'(SLOT_BYTES) + AW'(byte_index);
		mem_wdata   = write_value;
		ctrl.kind   = OUT_ZERO;
		ctrl.pwm    = 1'b0;
		idle        = active_q >= 4'(PACKET_COUNT);
		lk          = cmd_lookup(spi_in);
		p           = idle ? lk.id : active_q;
		idx         = idle ? '0 : cnt_q;
		case (req_t'(s_tuser))
			REQ_SPI: begin
				if (idle && !lk.hit) begin
					ctrl.kind = OUT_FF;
					act_nx    = IDLE_CODE;
				end else begin
					mem_en    = 1'b1;
					mem_we    = (p == STATUS_ID) || (p == SERVO_ID);
					mem_addr  = AW'(p) * AW'(SLOT_BYTES) + AW'(idx);
					mem_wdata = spi_in;
					cnt_nx    = idx + 4'd1;
					if ((5'(idx) + 5'd1) > pkt_len(p)) begin
						ctrl.pwm  = (p == SERVO_ID);
						ctrl.kind = OUT_FF;
						act_nx    = IDLE_CODE;
					end else begin
						ctrl.kind = OUT_SPI;
						act_nx    = p;
					end
				end
			end
			REQ_WR: begin
				mem_en = local_ok;
				mem_we = local_ok;
			end
			REQ_RD: begin
				mem_en    = local_ok;
				ctrl.kind = local_ok ? OUT_READ : OUT_ZERO;
			end
			default: begin
				ctrl.kind = OUT_ZERO;
			end
		endcase
		ctrl.in_pkt = act_nx < 4'(PACKET_COUNT);
	end

	sstr_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (acc && mem_en),
		.we     (mem_we),
		.addr   (mem_addr),
		.wdata  (mem_wdata),
		.rdata  (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= IDLE_CODE;
			cnt_q    <= '0;
			v_s1     <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (acc) begin
				active_q <= act_nx;
				cnt_q    <= cnt_nx;
			end
			if (acc) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ctrl_s1 <= ctrl;
		end
	end

	always_comb begin
		case (ctrl_s1.kind)
			OUT_FF:   spi_out = NO_DATA;
			OUT_SPI:  spi_out = rdata;
			default:  spi_out = '0;
		endcase
		read_value = (ctrl_s1.kind == OUT_READ) ? rdata : '0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= {6'b0, ctrl_s1.in_pkt, ctrl_s1.pwm, read_value, spi_out};
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

endmodule
